// ===== design/laqs_pkg.sv =====
// Shared types and codes for the array queue with linear search.
package laqs_pkg;

  // Request codes carried in req_type.
  typedef enum logic [2:0] {
    REQ_ENQ  = 3'd0,
    REQ_DEQ  = 3'd1,
    REQ_SRCH = 3'd2,
    REQ_SIZE = 3'd3,
    REQ_TRAV = 3'd4
  } req_e;

  // Result status codes.
  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_RETRY    = 3'd2,
    ST_EMPTY    = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_e;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE = 2'd0,
    S_EXEC = 2'd1,
    S_RD   = 2'd2,
    S_CHK  = 2'd3
  } state_e;

  typedef struct packed {
    logic [2:0]         req_type;
    logic signed [31:0] value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         status;
    logic signed [31:0] data_out;
    logic [3:0]         position;
    logic [3:0]         occupied;
    logic               last;
  } out_item_t;

  // Datapath conditions seen by the controller.
  typedef struct packed {
    logic is_enq;
    logic is_deq;
    logic is_srch;
    logic is_trav;
    logic empty;
    logic tail_full;
    logic match;
    logic at_end;
    logic out_free;
  } ctl_status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    in_take;
    logic    emit;
    status_e st;
    logic    data_sel;
    logic    pos_sel;
    logic    last;
    logic    enq_write;
    logic    cnt_clear;
    logic    head_inc;
    logic    idx_load;
    logic    idx_inc;
    logic    rd_en;
  } ctl_cmd_t;

endpackage

// ===== design/linear_array_queue_with_search_top.sv =====
// Top level of the linear array queue with linear search.
// A linear (non-circular) queue of DEPTH signed 32-bit entries with enqueue,
// dequeue, search, size and traverse requests. The block takes one item at a
// time: an item is taken only while the controller is idle, and a new item
// may be taken while the previous result still waits in the output register.
// Enqueue, size, and any request that finds the queue empty are answered in
// the execute state. Entries live in a RAM with a registered read, so every
// entry visited takes a read state and a check state: dequeue visits one,
// search visits entries up to a match or the end, traverse visits all live
// entries, and output stalls can hold any result. Slots are not reused until
// the queue drains and an enqueue at the end resets both counts with a retry status.
module linear_array_queue_with_search_top import laqs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      in_valid_i,
  output logic      in_stall_o,
  input  in_item_t  in_item_i,
  output logic      out_valid_o,
  input  logic      out_stall_i,
  output out_item_t out_item_o
);

  ctl_cmd_t    cmd;
  ctl_status_t stat;

  // Request sequencing.
  laqs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // Counts, store and result register.
  laqs_dp #(
    .DEPTH(DEPTH)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ===== design/laqs_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module laqs_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, held when not enabled.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/laqs_ctrl.sv =====
// Controller state machine for the array queue with linear search.
module laqs_ctrl import laqs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  ctl_status_t stat_i,
  output ctl_cmd_t    cmd_o
);

  state_e state_q, state_d;

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_EXEC;
      end
      S_EXEC: begin
        if ((stat_i.is_deq || stat_i.is_srch || stat_i.is_trav) && !stat_i.empty) begin
          state_d = S_RD;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      S_RD: begin
        state_d = S_CHK;
      end
      S_CHK: begin
        if (stat_i.is_srch) begin
          if (stat_i.match || stat_i.at_end) begin
            if (stat_i.out_free) state_d = S_IDLE;
          end else begin
            state_d = S_RD;
          end
        end else if (stat_i.is_trav) begin
          if (stat_i.out_free) state_d = stat_i.at_end ? S_IDLE : S_RD;
        end else if (stat_i.out_free) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs.
  always_comb begin
    cmd_o      = '0;
    cmd_o.st   = ST_OK;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: begin
        cmd_o.in_take = in_valid_i;
      end
      S_EXEC: begin
        if ((stat_i.is_deq || stat_i.is_srch || stat_i.is_trav) && !stat_i.empty) begin
          cmd_o.idx_load = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.emit = 1'b1;
          cmd_o.last = 1'b1;
          if (stat_i.is_enq) begin
            if (!stat_i.tail_full) begin
              cmd_o.enq_write = 1'b1;
            end else if (stat_i.empty) begin
              cmd_o.st        = ST_RETRY;
              cmd_o.cnt_clear = 1'b1;
            end else begin
              cmd_o.st = ST_FULL;
            end
          end else if (stat_i.is_deq || stat_i.is_srch || stat_i.is_trav) begin
            cmd_o.st = ST_EMPTY;
          end
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
      end
      S_CHK: begin
        if (stat_i.is_srch) begin
          if (stat_i.match) begin
            cmd_o.emit    = stat_i.out_free;
            cmd_o.pos_sel = 1'b1;
            cmd_o.last    = 1'b1;
          end else if (stat_i.at_end) begin
            cmd_o.emit = stat_i.out_free;
            cmd_o.st   = ST_NOTFOUND;
            cmd_o.last = 1'b1;
          end else begin
            cmd_o.idx_inc = 1'b1;
          end
        end else if (stat_i.is_trav) begin
          cmd_o.emit     = stat_i.out_free;
          cmd_o.data_sel = 1'b1;
          cmd_o.last     = stat_i.at_end;
          cmd_o.idx_inc  = stat_i.out_free && !stat_i.at_end;
        end else begin
          // Dequeue.
          cmd_o.emit     = stat_i.out_free;
          cmd_o.data_sel = 1'b1;
          cmd_o.last     = 1'b1;
          cmd_o.head_inc = stat_i.out_free;
        end
      end
      default: begin
        cmd_o.st = ST_OK;
      end
    endcase
  end

endmodule

// ===== design/laqs_dp.sv =====
// Datapath: counts, scan index, entry store and output register.
module laqs_dp import laqs_pkg::*; #(
  parameter int DEPTH = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  in_item_t    in_item_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output out_item_t   out_item_o,
  input  ctl_cmd_t    cmd_i,
  output ctl_status_t stat_o
);

  localparam int AW   = $clog2(DEPTH);
  localparam int CntW = $clog2(DEPTH + 1);

  logic [CntW-1:0]    head_q, head_d, tail_q, tail_d, idx_q, idx_nx, occ;
  logic [2:0]         req_q;
  logic signed [31:0] key_q;
  logic [31:0]        rdata;
  logic               out_valid_q;
  out_item_t          out_q;

  // Request capture.
  always_ff @(posedge clk_i) begin
    if (cmd_i.in_take) begin
      req_q <= in_item_i.req_type;
      key_q <= in_item_i.value;
    end
  end

  // Head and tail counts.
  always_comb begin
    head_d = head_q;
    tail_d = tail_q;
    if (cmd_i.cnt_clear) begin
      head_d = '0;
      tail_d = '0;
    end else begin
      if (cmd_i.head_inc)  head_d = head_q + CntW'(1);
      if (cmd_i.enq_write) tail_d = tail_q + CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
    end else begin
      head_q <= head_d;
      tail_q <= tail_d;
    end
  end

  // Scan index over live entries.
  assign idx_nx = idx_q + CntW'(1);

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_load) begin
      idx_q <= head_q;
    end else if (cmd_i.idx_inc) begin
      idx_q <= idx_nx;
    end
  end

  // Entry store.
  laqs_ram #(
    .WIDTH(32),
    .DEPTH(DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.enq_write),
    .waddr_i (tail_q[AW-1:0]),
    .wdata_i (key_q),
    .re_i    (cmd_i.rd_en),
    .raddr_i (idx_q[AW-1:0]),
    .rdata_o (rdata)
  );

  // Request decode and conditions for the controller.
  always_comb begin
    stat_o = '0;
    case (req_q)
      REQ_ENQ:  stat_o.is_enq  = 1'b1;
      REQ_DEQ:  stat_o.is_deq  = 1'b1;
      REQ_SRCH: stat_o.is_srch = 1'b1;
      REQ_TRAV: stat_o.is_trav = 1'b1;
      default:  stat_o.is_enq  = 1'b0;
    endcase
    stat_o.empty     = (head_q == tail_q);
    stat_o.tail_full = (tail_q == CntW'(DEPTH));
    stat_o.match     = (rdata == key_q);
    stat_o.at_end    = (idx_nx == tail_q);
    stat_o.out_free  = !out_valid_q || !out_stall_i;
  end

  // Occupancy after the request.
  assign occ = tail_d - head_d;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_q.status   <= cmd_i.st;
      out_q.data_out <= cmd_i.data_sel ? rdata : '0;
      out_q.position <= cmd_i.pos_sel ? 4'(idx_nx) : 4'd0;
      out_q.occupied <= 4'(occ);
      out_q.last     <= cmd_i.last;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

  // The tail never falls behind the head.
  a_order: assert property (@(posedge clk_i) disable iff (!rst_ni) tail_q >= head_q)
    else $error("tail count below head count");

  // The tail never passes the end of the store.
  a_tail_max: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tail_q <= CntW'(DEPTH))
    else $error("tail count beyond the store");

  // A result is only loaded when the output register can take it.
  a_emit_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.emit |-> (!out_valid_q || !out_stall_i))
    else $error("result overwrites a pending item");

  // A retry status leaves both counts at zero.
  a_retry: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cmd_i.emit && cmd_i.st == ST_RETRY) |=> (head_q == '0 && tail_q == '0))
    else $error("counts not cleared on retry");

  // A store only happens with room at the tail.
  a_enq_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.enq_write |-> tail_q < CntW'(DEPTH))
    else $error("store past the end of the array");

endmodule
